FILE: sv/hdlec_pkg.sv
// Package for the half-duplex link echo controller.
// Holds the transfer structs, event and phase codes, and controller/datapath links.
// No dependencies.
package hdlec_pkg;

  typedef enum logic [2:0] {
    EV_WRITE   = 3'd0,
    EV_READ    = 3'd1,
    EV_RECV    = 3'd2,
    EV_RXERR   = 3'd3,
    EV_TXREADY = 3'd4,
    EV_TXEND   = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_TX   = 2'd1,
    PH_WAIT_ECHO = 2'd2
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] line_byte;
    logic       line_byte_valid;
    logic       transmit_enabled;
    logic       data_available;
    logic       collision;
    logic       overflow;
  } out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

endpackage

FILE: sv/hdlec_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hdlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/hdlec_ctrl.sv
// Controller state machine for the link echo controller.
// Depends on hdlec_pkg.
module hdlec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hdlec_pkg::status_t status,
  output hdlec_pkg::cmd_t    cmd
);
  import hdlec_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = status.out_blocked;
        if (in_valid && !status.out_blocked) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/hdlec_dp.sv
// Datapath: send phase, pending byte, receive FIFO pointers and result register.
// Depends on hdlec_pkg and hdlec_ram.
module hdlec_dp #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  hdlec_pkg::in_t     in_item,
  input  hdlec_pkg::cmd_t    cmd,
  output hdlec_pkg::status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output hdlec_pkg::out_t    out_item
);
  import hdlec_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [2:0]       ev;
  logic [7:0]       data;
  phase_t           phase, phase_next;
  logic [7:0]       pending, pending_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic             tx_on, tx_on_next;
  logic [PTR_W-1:0] rd_adv, wr_adv;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  out_t             result;

  hdlec_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(data),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev   <= in_item.func;
      data <= in_item.data;
    end
  end

  assign rd_adv = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_adv = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    rd_ptr_next  = rd_ptr;
    wr_ptr_next  = wr_ptr;
    tx_on_next   = tx_on;
    ram_we       = 1'b0;
    result       = '0;
    case (ev)
      EV_WRITE: begin
        pending_next = data;
        phase_next   = PH_WAIT_TX;
        tx_on_next   = 1'b1;
      end
      EV_READ: begin
        if (rd_ptr != wr_ptr) begin
          result.read_byte  = ram_rdata;
          result.read_valid = 1'b1;
          rd_ptr_next       = rd_adv;
        end
      end
      EV_RECV: begin
        if (phase == PH_IDLE) begin
          if (wr_adv == rd_ptr) begin
            result.overflow = 1'b1;
          end else begin
            ram_we      = cmd.execute;
            wr_ptr_next = wr_adv;
          end
        end else begin
          if (data != pending) begin
            result.collision = 1'b1;
            tx_on_next       = 1'b0;
          end
          phase_next = PH_IDLE;
        end
      end
      EV_RXERR: begin
        if (phase != PH_IDLE) begin
          tx_on_next = 1'b0;
        end
      end
      EV_TXREADY: begin
        if (phase == PH_WAIT_TX) begin
          result.line_byte       = pending;
          result.line_byte_valid = 1'b1;
          phase_next             = PH_WAIT_ECHO;
        end
      end
      EV_TXEND: begin
        tx_on_next = 1'b0;
      end
      default: begin
      end
    endcase
    result.transmit_enabled = tx_on_next;
    result.data_available   = (rd_ptr_next != wr_ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      tx_on   <= 1'b0;
    end else if (cmd.execute) begin
      phase   <= phase_next;
      pending <= pending_next;
      rd_ptr  <= rd_ptr_next;
      wr_ptr  <= wr_ptr_next;
      tx_on   <= tx_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_item <= result;
    end
  end

  assign status.out_blocked = out_valid && out_stall;

endmodule

FILE: sv/half_duplex_link_echo_controller_core.sv
// Top level of the half-duplex link echo controller.
// Depends on hdlec_pkg, hdlec_ctrl and hdlec_dp.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   in_item  (func, data)
//   output   out_valid / out_stall out_item (read/line bytes, status flags)
//
// Each event is first captured while the FIFO RAM performs its registered read,
// then executed: the link state is updated and the result register loaded.
// An event is accepted only while the controller is idle and the result register
// is empty or transferring out, so no new event is taken while one executes.
// Reset is synchronous and clears phase, pointers and the transmitter flag.
// A stalled result holds in_stall high until it transfers.
module half_duplex_link_echo_controller_core #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  hdlec_pkg::in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output hdlec_pkg::out_t out_item
);
  import hdlec_pkg::*;

  cmd_t    cmd;
  status_t status;

  hdlec_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  hdlec_dp #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted event produced no result");

  a_exec_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("capture not followed by execute");

  a_result_reg_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !out_valid)
    else $error("result register overwritten while full");
`endif

endmodule

FILE: dv/tb_top.sv
// Testbench for half_duplex_link_echo_controller_core: directed and random link events,
// checked transfer by transfer against a behavioral model of the link state and receive FIFO.
// Depends on hdlec_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlec_pkg::*;

  localparam int FIFO_DEPTH = 32;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_EVENTS = 500;
  localparam logic [2:0] EV_SPARE_LO = 3'd6;
  localparam logic [2:0] EV_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  half_duplex_link_echo_controller_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  in_t event_queue[$];
  out_t expected_results[$];
  int total_events = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;

  phase_t link_phase = PH_IDLE;
  logic [7:0] pend_byte = '0;
  logic [7:0] rx_fifo[FIFO_DEPTH];
  int rd_ptr = 0;
  int wr_ptr = 0;
  logic tx_on = 1'b0;

  function automatic out_t predict_link_event(in_t item);
    out_t res;
    int nxt;
    res = '0;
    case (item.func)
      EV_WRITE: begin
        pend_byte = item.data;
        link_phase = PH_WAIT_TX;
        tx_on = 1'b1;
      end
      EV_READ: begin
        if (rd_ptr != wr_ptr) begin
          res.read_byte = rx_fifo[rd_ptr];
          res.read_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        end
      end
      EV_RECV: begin
        if (link_phase == PH_IDLE) begin
          nxt = (wr_ptr + 1) % FIFO_DEPTH;
          if (nxt == rd_ptr) begin
            res.overflow = 1'b1;
          end else begin
            rx_fifo[wr_ptr] = item.data;
            wr_ptr = nxt;
          end
        end else begin
          if (item.data != pend_byte) begin
            res.collision = 1'b1;
            tx_on = 1'b0;
          end
          link_phase = PH_IDLE;
        end
      end
      EV_RXERR: begin
        if (link_phase != PH_IDLE) tx_on = 1'b0;
      end
      EV_TXREADY: begin
        if (link_phase == PH_WAIT_TX) begin
          res.line_byte = pend_byte;
          res.line_byte_valid = 1'b1;
          link_phase = PH_WAIT_ECHO;
        end
      end
      EV_TXEND: begin
        tx_on = 1'b0;
      end
      default: ;
    endcase
    res.transmit_enabled = tx_on;
    res.data_available = (rd_ptr != wr_ptr);
    return res;
  endfunction

  task automatic push_event(input logic [2:0] func, input logic [7:0] data);
    in_t item;
    item.func = func;
    item.data = data;
    event_queue.push_back(item);
  endtask

  task automatic push_send_sequence();
    logic [7:0] byte_out;
    byte_out = 8'($urandom);
    push_event(EV_WRITE, byte_out);
    if ($urandom_range(0, 5) == 0) begin
      byte_out = 8'($urandom);
      push_event(EV_WRITE, byte_out);
    end
    if ($urandom_range(0, 4) == 0) push_event(EV_RXERR, 8'($urandom));
    if ($urandom_range(0, 7) != 0) push_event(EV_TXREADY, 8'($urandom));
    if ($urandom_range(0, 5) == 0) push_event(EV_TXREADY, 8'($urandom));
    if ($urandom_range(0, 4) == 0) push_event(EV_TXEND, 8'($urandom));
    if ($urandom_range(0, 3) == 0)
      push_event(EV_RECV, byte_out ^ 8'($urandom_range(1, 255)));
    else
      push_event(EV_RECV, byte_out);
  endtask

  task automatic build_stimulus();
    int count;
    push_event(EV_READ, 8'h00);
    push_event(EV_RXERR, 8'hFF);
    push_event(EV_TXREADY, 8'h00);
    push_event(EV_TXEND, 8'hFF);
    push_event(EV_WRITE, 8'h00);
    push_event(EV_WRITE, 8'hFF);
    push_event(EV_RXERR, 8'h00);
    push_event(EV_TXREADY, 8'h00);
    push_event(EV_TXREADY, 8'hFF);
    push_event(EV_RECV, 8'hFF);
    push_event(EV_WRITE, 8'h5A);
    push_event(EV_RECV, 8'hA5);
    push_event(EV_WRITE, 8'h81);
    push_event(EV_TXREADY, 8'h00);
    push_event(EV_RECV, 8'h80);
    push_event(EV_RECV, 8'hFF);
    push_event(EV_RECV, 8'h00);
    push_event(EV_SPARE_LO, 8'hFF);
    push_event(EV_SPARE_HI, 8'h00);
    push_event(EV_READ, 8'hFF);
    push_event(EV_READ, 8'h00);
    push_event(EV_READ, 8'h00);
    push_event(EV_WRITE, 8'h3C);
    push_event(EV_TXREADY, 8'h00);
    push_event(EV_TXEND, 8'h00);
    push_event(EV_RECV, 8'h3C);
    count = event_queue.size();
    while (event_queue.size() < count + RANDOM_EVENTS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: push_send_sequence();
        9, 10, 11: begin
          count = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 8);
          repeat (count) push_event(EV_RECV, 8'($urandom));
        end
        12, 13, 14: begin
          count = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
          repeat (count) push_event(EV_READ, 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_event(3'($urandom_range(0, 7)), 8'($urandom));
        end
      endcase
      count = 26;
    end
    total_events = event_queue.size();
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_link_event(in_item));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_queue.size() > 0) begin
          in_item <= event_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transfer: actual %h", out_item);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.read_byte !== exp_res.read_byte ||
            out_item.read_valid !== exp_res.read_valid ||
            out_item.line_byte !== exp_res.line_byte ||
            out_item.line_byte_valid !== exp_res.line_byte_valid ||
            out_item.transmit_enabled !== exp_res.transmit_enabled ||
            out_item.data_available !== exp_res.data_available ||
            out_item.collision !== exp_res.collision ||
            out_item.overflow !== exp_res.overflow) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch on transfer %0d: expected rb=%h rv=%b lb=%h lv=%b ",
                      "te=%b da=%b col=%b ovf=%b, actual rb=%h rv=%b lb=%h lv=%b ",
                      "te=%b da=%b col=%b ovf=%b"}, results_seen,
                     exp_res.read_byte, exp_res.read_valid, exp_res.line_byte,
                     exp_res.line_byte_valid, exp_res.transmit_enabled,
                     exp_res.data_available, exp_res.collision, exp_res.overflow,
                     out_item.read_byte, out_item.read_valid, out_item.line_byte,
                     out_item.line_byte_valid, out_item.transmit_enabled,
                     out_item.data_available, out_item.collision, out_item.overflow);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** half_duplex_link_echo_controller_core: FAILED **");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (accepted_count < total_events || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("** half_duplex_link_echo_controller_core: PASSED **");
    end else begin
      $display("** half_duplex_link_echo_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/hdlec_pkg.sv
sv/hdlec_ram.sv
sv/hdlec_ctrl.sv
sv/hdlec_dp.sv
sv/half_duplex_link_echo_controller_core.sv
dv/tb_top.sv
